// ----- design/lcdnw_pkg.sv -----
// Shared types, request codes and step script for the LCD nibble write sequencer.
// Used by lcdnw_ctrl, lcdnw_dpath and the top level; depends on nothing else.
package lcdnw_pkg;

  // Request kinds
  localparam logic [1:0] FUNC_CMD   = 2'd0;
  localparam logic [1:0] FUNC_DATA  = 2'd1;
  localparam logic [1:0] FUNC_INIT  = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  // Phases of one byte write on the 4-bit bus
  localparam logic [2:0] PH_SETUP   = 3'd0;
  localparam logic [2:0] PH_HI_EN   = 3'd1;
  localparam logic [2:0] PH_HI_HOLD = 3'd2;
  localparam logic [2:0] PH_LO_EN   = 3'd3;
  localparam logic [2:0] PH_LO_HOLD = 3'd4;

  // Step holds in microseconds
  localparam logic [13:0] SETUP_US     = 14'd50;
  localparam logic [13:0] PULSE_US     = 14'd1;
  localparam logic [13:0] POWERUP_US   = 14'd15000;
  localparam logic [13:0] INIT_WAIT1_US = 14'd4000;
  localparam logic [13:0] INIT_WAIT2_US = 14'd100;
  localparam logic [13:0] CLEAR_US     = 14'd1000;

  // Controller command bytes
  localparam logic [7:0] CMD_FUNC_8BIT = 8'h38;
  localparam logic [7:0] CMD_FUNC_4BIT = 8'h28;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;

  // One operation of a request script: a byte write or a pure wait
  typedef struct packed {
    logic        is_wait;
    logic        from_input;
    logic [7:0]  byte_val;
    logic [13:0] wait_us;
    logic        last_op;
  } op_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       emit;
    op_t        op;
    logic [2:0] phase;
    logic       last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       slot_free;
    logic [1:0] func;
  } stat_t;

  function automatic op_t mk_byte(input logic [7:0] b, input logic last_op);
    op_t o;
    o.is_wait    = 1'b0;
    o.from_input = 1'b0;
    o.byte_val   = b;
    o.wait_us    = '0;
    o.last_op    = last_op;
    return o;
  endfunction

  function automatic op_t mk_wait(input logic [13:0] us, input logic last_op);
    op_t o;
    o.is_wait    = 1'b1;
    o.from_input = 1'b0;
    o.byte_val   = '0;
    o.wait_us    = us;
    o.last_op    = last_op;
    return o;
  endfunction

  // Script of operations for each request kind
  function automatic op_t script_op(input logic [1:0] func, input logic [3:0] idx);
    op_t o;
    o = mk_wait('0, 1'b1);
    unique case (func)
      FUNC_CMD, FUNC_DATA: begin
        o = mk_byte('0, 1'b1);
        o.from_input = 1'b1;
      end
      FUNC_CLEAR: begin
        if (idx == 4'd0) o = mk_byte(CMD_CLEAR, 1'b0);
        else             o = mk_wait(CLEAR_US, 1'b1);
      end
      FUNC_INIT: begin
        unique case (idx)
          4'd0:    o = mk_wait(POWERUP_US, 1'b0);
          4'd1:    o = mk_byte(CMD_FUNC_8BIT, 1'b0);
          4'd2:    o = mk_wait(INIT_WAIT1_US, 1'b0);
          4'd3:    o = mk_byte(CMD_FUNC_8BIT, 1'b0);
          4'd4:    o = mk_wait(INIT_WAIT2_US, 1'b0);
          4'd5:    o = mk_byte(CMD_FUNC_8BIT, 1'b0);
          4'd6:    o = mk_byte(CMD_FUNC_4BIT, 1'b0);
          4'd7:    o = mk_byte(CMD_FUNC_4BIT, 1'b0);
          4'd8:    o = mk_byte(CMD_DISP_ON, 1'b0);
          4'd9:    o = mk_byte(CMD_CLEAR, 1'b0);
          4'd10:   o = mk_wait(CLEAR_US, 1'b0);
          4'd11:   o = mk_byte(CMD_ENTRY, 1'b1);
          default: o = mk_wait('0, 1'b1);
        endcase
      end
      default: o = mk_wait('0, 1'b1);
    endcase
    return o;
  endfunction

endpackage

// ----- design/char_lcd_nibble_write_sequencer.sv -----
// Character LCD nibble write sequencer: expands one request into timed pin steps.
// Top level; depends on lcdnw_pkg, lcdnw_ctrl and lcdnw_dpath.
//
// Input channel (in_valid_i/in_ready_o): func_i selects a command byte, a data byte,
// the power-up init sequence or a clear; value_i is the byte for command and data.
// Output channel (out_valid_o/out_ready_i): one transaction per pin step carrying
// reg_select_o, enable_o, nibble_o, wait_us_o (hold in microseconds) and last_o,
// which marks the final step of the request.
// A byte write gives 5 steps, a clear 6 and init 44. The first step is loaded into the
// output register after the controller has entered its run state on the accepting edge;
// later steps follow one per cycle while the receiver takes them. The controller emits
// one step per cycle from a single output register while that register is free.
// A new request is taken once the last step of the previous one has been loaded
// into the output register.
// When the receiver stalls, the output register holds its step and the controller
// waits; no step is lost or repeated.
// Reset returns the controller to idle and empties the output register.
module char_lcd_nibble_write_sequencer
  import lcdnw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        reg_select_o,
  output logic        enable_o,
  output logic [3:0]  nibble_o,
  output logic [13:0] wait_us_o,
  output logic        last_o
);

  cmd_t  cmd;
  stat_t stat;

  lcdnw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lcdnw_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .func_i       (func_i),
    .value_i      (value_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .reg_select_o (reg_select_o),
    .enable_o     (enable_o),
    .nibble_o     (nibble_o),
    .wait_us_o    (wait_us_o),
    .last_o       (last_o)
  );

endmodule

// ----- design/lcdnw_ctrl.sv -----
// Sequencing controller: walks the operation script of a request, phase by phase.
// Depends on lcdnw_pkg; drives lcdnw_dpath through cmd_t and reads stat_t.
module lcdnw_ctrl
  import lcdnw_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic       state_q, state_d;
  logic [3:0] idx_q, idx_d;
  logic [2:0] phase_q, phase_d;
  op_t        op;
  logic       op_done;
  logic       load;
  logic       emit;

  // Look up the current operation and decide whether it ends with this step
  assign op      = script_op(stat_i.func, idx_q);
  assign op_done = op.is_wait || (phase_q == PH_LO_HOLD);

  assign in_ready_o = (state_q == ST_IDLE);
  assign load       = in_valid_i && in_ready_o;
  assign emit       = (state_q == ST_RUN) && stat_i.slot_free;

  // Issue commands
  always_comb begin
    cmd_o.load  = load;
    cmd_o.emit  = emit;
    cmd_o.op    = op;
    cmd_o.phase = phase_q;
    cmd_o.last  = op.last_op && op_done;
  end

  // Advance phase and operation index
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    phase_d = phase_q;
    if (load) begin
      state_d = ST_RUN;
      idx_d   = '0;
      phase_d = PH_SETUP;
    end else if (emit) begin
      if (op_done) begin
        phase_d = PH_SETUP;
        if (op.last_op) state_d = ST_IDLE;
        else            idx_d   = idx_q + 4'd1;
      end else begin
        phase_d = phase_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      phase_q <= PH_SETUP;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      phase_q <= phase_d;
    end
  end

endmodule

// ----- design/lcdnw_dpath.sv -----
// Datapath: request registers, pin-step builder and the output register.
// Depends on lcdnw_pkg; commanded by lcdnw_ctrl.
module lcdnw_dpath
  import lcdnw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [1:0]  func_i,
  input  logic [7:0]  value_i,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        reg_select_o,
  output logic        enable_o,
  output logic [3:0]  nibble_o,
  output logic [13:0] wait_us_o,
  output logic        last_o
);

  logic [1:0]  func_q;
  logic [7:0]  value_q;
  logic        prev_rs_q;
  logic [3:0]  prev_nib_q;
  logic        out_valid_q;
  logic        rs_q, en_q, last_q;
  logic [3:0]  nib_q;
  logic [13:0] wait_q;

  logic        step_rs, step_en;
  logic [3:0]  step_nib;
  logic [13:0] step_wait;
  logic [7:0]  bval;

  assign stat_o.slot_free = !out_valid_q || out_ready_i;
  assign stat_o.func      = func_q;

  // Build the pin step for the current operation and phase
  always_comb begin
    bval      = cmd_i.op.from_input ? value_q : cmd_i.op.byte_val;
    step_rs   = cmd_i.op.from_input ? func_q[0] : 1'b0;
    step_nib  = (cmd_i.phase >= PH_LO_EN) ? bval[3:0] : bval[7:4];
    step_en   = (cmd_i.phase == PH_HI_EN) || (cmd_i.phase == PH_LO_EN);
    unique case (cmd_i.phase)
      PH_SETUP:            step_wait = SETUP_US;
      PH_HI_EN, PH_LO_EN:  step_wait = PULSE_US;
      default:             step_wait = '0;
    endcase
    // A pure wait keeps the pins of the step before it
    if (cmd_i.op.is_wait) begin
      step_rs   = prev_rs_q;
      step_nib  = prev_nib_q;
      step_en   = 1'b0;
      step_wait = cmd_i.op.wait_us;
    end
  end

  // Hold the request and the pins last presented
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q     <= func_i;
      value_q    <= value_i;
      prev_rs_q  <= 1'b0;
      prev_nib_q <= '0;
    end else if (cmd_i.emit) begin
      prev_rs_q  <= step_rs;
      prev_nib_q <= step_nib;
    end
  end

  // Output register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      rs_q   <= step_rs;
      en_q   <= step_en;
      nib_q  <= step_nib;
      wait_q <= step_wait;
      last_q <= cmd_i.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign reg_select_o = rs_q;
  assign enable_o     = en_q;
  assign nibble_o     = nib_q;
  assign wait_us_o    = wait_q;
  assign last_o       = last_q;

endmodule
